### rtl/adl32_pkg.sv
// Package for the wide Adler-32 checksum engine: widths, register indexes,
// the modulus and the shared reduction function.
// Used by every module of the block; depends on nothing.
package adl32_pkg;

	// Adler-32 modulus, one bit wider than the sums so that it compares against raw adds.
	localparam logic [16:0] ADLER_MOD = 17'd65521;

	// The data field carries eight bytes at most.
	localparam int WORD_LANES         = 8;
	localparam int DEF_BYTES_PER_ITEM = 8;

	// Field widths.
	localparam int DATA_W    = 64;
	localparam int CNT_W     = 4;
	localparam int SUM_W     = 16;
	localparam int TOTAL_W   = 11;  // eight bytes of 255 at most
	localparam int WSUM_W    = 14;  // 255 times (8 + 7 + ... + 1) at most
	localparam int PROD_W    = 12;  // one byte times a weight of up to 8
	localparam int CFG_IDX_W = 8;

	// Stream widths.
	localparam int S_TDATA_W = 72;
	localparam int M_TDATA_W = 64;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SEED_LOW  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEED_HIGH = 8'd1;

	// Reset values of the seeds and of the running sums.
	localparam logic [SUM_W-1:0] LOW_RESET  = 16'd1;
	localparam logic [SUM_W-1:0] HIGH_RESET = 16'd0;

	// Per-item lane totals handed from the lane stage to the accumulator.
	typedef struct packed {
		logic [TOTAL_W-1:0] total;
		logic [WSUM_W-1:0]  weighted;
		logic [CNT_W-1:0]   count;
		logic               first;
	} lane_sum_t;

	// Reduces a value below twice the modulus into 0..65520.
	function automatic logic [SUM_W-1:0] mod_reduce(input logic [16:0] v);
		logic [16:0] r;
		r = (v >= ADLER_MOD) ? (v - ADLER_MOD) : v;
		return r[SUM_W-1:0];
	endfunction

endpackage

### rtl/adl32_lane_sum.sv
// Lane stage of the wide Adler-32 engine: input register, then the byte total
// and the position-weighted byte sum of one word, registered.
// Depends on adl32_pkg.
module adl32_lane_sum #(
	parameter int LANES = adl32_pkg::DEF_BYTES_PER_ITEM
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [adl32_pkg::DATA_W-1:0]  in_data,
	input  logic [adl32_pkg::CNT_W-1:0]   in_count,
	input  logic                          in_first,
	output logic                          out_valid,
	input  logic                          out_ready,
	output adl32_pkg::lane_sum_t          out_item
);

	localparam logic [adl32_pkg::CNT_W-1:0] LANE_LIMIT = adl32_pkg::CNT_W'(LANES);

	logic                         valid_s1;
	logic [adl32_pkg::DATA_W-1:0] data_s1;
	logic [adl32_pkg::CNT_W-1:0]  count_s1;
	logic                         first_s1;
	logic                         valid_s2;
	adl32_pkg::lane_sum_t         item_s2;
	logic                         ready_s2;
	logic [adl32_pkg::CNT_W-1:0]  count_sat;

	logic [7:0]                   byte_m [LANES];
	logic [adl32_pkg::CNT_W-1:0]  weight [LANES];
	logic [adl32_pkg::PROD_W-1:0] prod   [LANES];
	logic [adl32_pkg::TOTAL_W-1:0] total;
	logic [adl32_pkg::WSUM_W-1:0]  weighted;

	// Each stage takes a new item when it is empty or its content moves on.
	assign ready_s2 = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || ready_s2;

	// Counts above the lane limit saturate.
	assign count_sat = (in_count > LANE_LIMIT) ? LANE_LIMIT : in_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1  <= in_data;
			count_s1 <= count_sat;
			first_s1 <= in_first;
		end
	end

	// Byte i weighs count - i; bytes past the count weigh nothing.
	for (genvar i = 0; i < LANES; i++) begin : g_lane
		assign byte_m[i] = (count_s1 > adl32_pkg::CNT_W'(i)) ? data_s1[8*i +: 8] : 8'd0;
		assign weight[i] = (count_s1 > adl32_pkg::CNT_W'(i)) ?
			(count_s1 - adl32_pkg::CNT_W'(i)) : '0;
		assign prod[i]   = adl32_pkg::PROD_W'(byte_m[i]) * adl32_pkg::PROD_W'(weight[i]);
	end

	// Adder over the lanes.
	always_comb begin
		total    = '0;
		weighted = '0;
		for (int i = 0; i < LANES; i++) begin
			total    = total + adl32_pkg::TOTAL_W'(byte_m[i]);
			weighted = weighted + adl32_pkg::WSUM_W'(prod[i]);
		end
	end

	// Lane result register.
	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			item_s2.total    <= total;
			item_s2.weighted <= weighted;
			item_s2.count    <= count_s1;
			item_s2.first    <= first_s1;
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = item_s2;

endmodule

### rtl/adl32_accum.sv
// Accumulator of the wide Adler-32 engine: updates both running sums modulo
// 65521 from one word's lane totals and holds them as the result register.
// Depends on adl32_pkg.
module adl32_accum (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  adl32_pkg::lane_sum_t         in_item,
	input  logic [adl32_pkg::SUM_W-1:0]  seed_low,
	input  logic [adl32_pkg::SUM_W-1:0]  seed_high,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [adl32_pkg::SUM_W-1:0]  low_sum,
	output logic [adl32_pkg::SUM_W-1:0]  high_sum
);

	logic                        valid_q;
	logic [adl32_pkg::SUM_W-1:0] low_q;
	logic [adl32_pkg::SUM_W-1:0] high_q;
	logic [adl32_pkg::SUM_W-1:0] a_base;
	logic [adl32_pkg::SUM_W-1:0] b_base;
	logic [16:0]                 a_sum;
	logic [19:0]                 a_scaled;
	logic [19:0]                 b_sum;
	logic [16:0]                 b_fold;
	logic [adl32_pkg::SUM_W-1:0] a_next;
	logic [adl32_pkg::SUM_W-1:0] b_next;

	assign in_ready = !valid_q || out_ready;

	// The first word of a message starts from the seeds (already reduced).
	assign a_base = in_item.first ? seed_low  : low_q;
	assign b_base = in_item.first ? seed_high : high_q;

	// Byte sum: one add and one conditional subtract.
	assign a_sum  = 17'(a_base) + 17'(in_item.total);
	assign a_next = adl32_pkg::mod_reduce(a_sum);

	// Sum of sums: count times old byte sum plus the weighted bytes, below 2^20.
	assign a_scaled = 20'(a_base) * 20'(in_item.count);
	assign b_sum    = 20'(b_base) + a_scaled + 20'(in_item.weighted);

	// 2^16 is 15 modulo 65521, so the upper bits fold back in times fifteen.
	assign b_fold = 17'(b_sum[15:0]) + (17'(b_sum[19:16]) * 17'd15);
	assign b_next = adl32_pkg::mod_reduce(b_fold);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			low_q   <= adl32_pkg::LOW_RESET;
			high_q  <= adl32_pkg::HIGH_RESET;
		end else begin
			if (in_ready) begin
				valid_q <= in_valid;
			end
			if (in_valid && in_ready) begin
				low_q  <= a_next;
				high_q <= b_next;
			end
		end
	end

	assign out_valid = valid_q;
	assign low_sum   = low_q;
	assign high_sum  = high_q;

endmodule

### rtl/adler32_wide_checksum.sv
// Top level of the wide Adler-32 checksum engine: stream ports, seed registers
// and the two pipeline parts. Depends on adl32_pkg, adl32_lane_sum and adl32_accum.
//
// Takes one word of up to eight bytes per transfer, byte 0 first in the stream,
// and returns one result per word: both running sums and the packed checksum
// after that word. The engine accepts a word every clock cycle while m_tready
// does not hold back the result. The input register loads at the transfer edge,
// then the lane adder register and then the accumulator register, which holds
// the word's result until it is taken. The accumulator closes the running-sum
// loop on its own register, which sets that rate.
// Setting first on a word restarts the sums from the seed registers; seeds of
// 65521 or more are reduced when written. Byte counts above the lane limit
// saturate, and a count of zero just reports the current sums. The seed registers
// may be written only while no word is in flight.
module adler32_wide_checksum #(
	parameter int BYTES_PER_ITEM = adl32_pkg::DEF_BYTES_PER_ITEM
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Input word stream.
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// s_tdata: data_bytes [63:0], byte_count [67:64], zero [71:68]
	input  logic [adl32_pkg::S_TDATA_W-1:0]  s_tdata,
	// s_tuser: first [0]
	input  logic                             s_tuser,
	// Result stream.
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// m_tdata: low_sum [15:0], high_sum [31:16], checksum [63:32]
	output logic [adl32_pkg::M_TDATA_W-1:0]  m_tdata,
	// Configuration write channel.
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [adl32_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [adl32_pkg::SUM_W-1:0]      cfg_data
);

	localparam int LANES = (BYTES_PER_ITEM > adl32_pkg::WORD_LANES) ?
		adl32_pkg::WORD_LANES : BYTES_PER_ITEM;

	logic [adl32_pkg::SUM_W-1:0] seed_low_q;
	logic [adl32_pkg::SUM_W-1:0] seed_high_q;
	logic                        lane_valid;
	logic                        lane_ready;
	adl32_pkg::lane_sum_t        lane_item;
	logic [adl32_pkg::SUM_W-1:0] low_sum;
	logic [adl32_pkg::SUM_W-1:0] high_sum;

	// Seed registers hold the reduced seed, so loading takes no extra logic.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_low_q  <= adl32_pkg::LOW_RESET;
			seed_high_q <= adl32_pkg::HIGH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				adl32_pkg::REG_SEED_LOW: begin
					seed_low_q <= adl32_pkg::mod_reduce(17'(cfg_data));
				end
				adl32_pkg::REG_SEED_HIGH: begin
					seed_high_q <= adl32_pkg::mod_reduce(17'(cfg_data));
				end
				default: begin
				end
			endcase
		end
	end

	// Lane totals per word.
	adl32_lane_sum #(
		.LANES(LANES)
	) u_lane_sum (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (s_tdata[63:0]),
		.in_count  (s_tdata[67:64]),
		.in_first  (s_tuser),
		.out_valid (lane_valid),
		.out_ready (lane_ready),
		.out_item  (lane_item)
	);

	// Running sums and result register.
	adl32_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (lane_valid),
		.in_ready  (lane_ready),
		.in_item   (lane_item),
		.seed_low  (seed_low_q),
		.seed_high (seed_high_q),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.low_sum   (low_sum),
		.high_sum  (high_sum)
	);

	// Result packing; the checksum is high_sum over low_sum.
	assign m_tdata = {high_sum, low_sum, high_sum, low_sum};

endmodule
